### sv/akt_pkg.sv
// ============================================================================
// akt_pkg
// Shared types, codes and defaults for the aging key table.
// ============================================================================
`default_nettype none

package akt_pkg;

   localparam int TABLE_DEPTH_DEF = 16;
   localparam logic [31:0] TIMEOUT_RESET = 32'd30;

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_FIND    = 3'd1,
      OP_DELETE  = 3'd2,
      OP_REFRESH = 3'd3,
      OP_SWEEP   = 3'd4,
      OP_RELEASE = 3'd5
   } akt_op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL      = 3'd2,
      ST_NONE_EXP  = 3'd3,
      ST_NOT_HELD  = 3'd4
   } akt_status_type;

   typedef enum logic [1:0] {
      MODE_FREE   = 2'd0,
      MODE_ACTIVE = 2'd1,
      MODE_HELD   = 2'd2
   } akt_mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_READ,
      S_COMPARE,
      S_DONE
   } akt_state_type;

   typedef struct packed {
      logic accept;
      logic insert;
      logic read;
      logic fail;
      logic apply;
      logic advance;
      logic publish;
   } akt_cmd_type;

   typedef struct packed {
      logic cur_null;
      logic release_ok;
      logic match;
      logic rsp_free;
   } akt_stat_type;

endpackage

`default_nettype wire

### sv/akt_ram.sv
// ============================================================================
// akt_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
`default_nettype none

module akt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### sv/akt_ctrl.sv
// ============================================================================
// akt_ctrl
// Sequencer: accepts an item, walks the active list, issues table updates.
// ============================================================================
`default_nettype none

module akt_ctrl
   import akt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic [2:0]   req_opcode,
   output logic              req_stall,
   input  wire akt_stat_type stat,
   output akt_cmd_type       cmd
);

   akt_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_opcode == OP_INSERT) begin
                  state_in = S_INSERT;
               end else if (req_opcode == OP_FIND || req_opcode == OP_DELETE ||
                            req_opcode == OP_REFRESH || req_opcode == OP_SWEEP ||
                            req_opcode == OP_RELEASE) begin
                  state_in = S_READ;
               end
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_DONE;
         end
         S_READ: begin
            if (!stat.release_ok && stat.cur_null) begin
               cmd.fail = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.read = 1'b1;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            if (stat.match) begin
               cmd.apply = 1'b1;
               state_in  = S_DONE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_READ;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> $past(state_in) == S_IDLE || $past(reset) || state_ff == S_IDLE)
      else $error("accept outside idle");
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> stat.rsp_free)
      else $error("publish while output busy");
   a_apply_after_read: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> $past(cmd.read))
      else $error("apply without read");

endmodule

`default_nettype wire

### sv/akt_datapath.sv
// ============================================================================
// akt_datapath
// Slot tables, free stack, active list links, key/stamp RAMs, result regs.
// ============================================================================
`default_nettype none

module akt_datapath
   import akt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire akt_cmd_type cmd,
   output akt_stat_type     stat,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [31:0] req_key,
   input  wire logic [31:0] req_now_time,
   input  wire logic [3:0]  req_slot_in,
   input  wire logic        cfg_we,
   input  wire logic [31:0] cfg_wdata,
   output logic [31:0]      cfg_timeout,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_slot_out,
   output logic [31:0]      rsp_key_out
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int IW = $clog2(TABLE_DEPTH + 1);
   localparam logic [IW-1:0] NULL_IDX = IW'(TABLE_DEPTH);

   logic [IW-1:0]  next_ff [TABLE_DEPTH];
   logic [IW-1:0]  prev_ff [TABLE_DEPTH];
   akt_mode_type   mode_ff [TABLE_DEPTH];
   logic [IW-1:0]  head_ff, free_ff, cur_ff;
   logic [2:0]     op_ff;
   logic [31:0]    key_ff, now_ff, timeout_ff;
   logic [2:0]     res_status_ff;
   logic [3:0]     res_slot_ff;
   logic [31:0]    res_key_ff;
   logic           rsp_valid_ff;
   logic [2:0]     rsp_status_ff;
   logic [3:0]     rsp_slot_ff;
   logic [31:0]    rsp_key_ff;

   logic [AW-1:0]  cur_a;
   logic [IW-1:0]  p_idx, n_idx;
   logic [31:0]    key_rd, stamp_rd, age;
   logic           sin_ok, insert_ok, do_unlink, do_push, stamp_we;

   assign cur_a  = cur_ff[AW-1:0];
   assign p_idx  = prev_ff[cur_a];
   assign n_idx  = next_ff[cur_a];
   assign age    = now_ff - stamp_rd;
   assign sin_ok = 32'(req_slot_in) < 32'(TABLE_DEPTH);
   assign insert_ok = cmd.insert && (free_ff != NULL_IDX);
   assign do_unlink = cmd.apply && (op_ff == OP_DELETE || op_ff == OP_SWEEP);
   assign do_push   = cmd.apply && (op_ff == OP_DELETE || op_ff == OP_RELEASE);
   assign stamp_we  = insert_ok || (cmd.apply && op_ff == OP_REFRESH);

   akt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (insert_ok),
      .wr_addr (cur_a),
      .wr_data (key_ff),
      .rd_en   (cmd.read),
      .rd_addr (cur_a),
      .rd_data (key_rd)
   );

   akt_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_we),
      .wr_addr (cur_a),
      .wr_data (now_ff),
      .rd_en   (cmd.read),
      .rd_addr (cur_a),
      .rd_data (stamp_rd)
   );

   // a release of a slot that is not held ends the item like an empty walk
   always_comb begin
      stat.release_ok = (op_ff == OP_RELEASE) && (cur_ff != NULL_IDX) &&
                        (mode_ff[cur_a] == MODE_HELD);
      stat.cur_null   = (cur_ff == NULL_IDX) ||
                        ((op_ff == OP_RELEASE) && !stat.release_ok);
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
      case (op_ff)
         OP_FIND, OP_DELETE, OP_REFRESH: stat.match = (key_rd == key_ff);
         OP_SWEEP:                       stat.match = (age > timeout_ff);
         OP_RELEASE:                     stat.match = 1'b1;
         default:                        stat.match = 1'b0;
      endcase
   end

   // list and free stack
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            next_ff[i] <= (i == 0) ? NULL_IDX : IW'(i - 1);
            prev_ff[i] <= NULL_IDX;
            mode_ff[i] <= MODE_FREE;
         end
         head_ff <= NULL_IDX;
         free_ff <= IW'(TABLE_DEPTH - 1);
      end else begin
         if (insert_ok) begin
            free_ff        <= n_idx;
            mode_ff[cur_a] <= MODE_ACTIVE;
            prev_ff[cur_a] <= NULL_IDX;
            next_ff[cur_a] <= head_ff;
            if (head_ff != NULL_IDX) begin
               prev_ff[head_ff[AW-1:0]] <= cur_ff;
            end
            head_ff <= cur_ff;
         end
         if (do_unlink) begin
            if (p_idx != NULL_IDX) begin
               next_ff[p_idx[AW-1:0]] <= n_idx;
            end else begin
               head_ff <= n_idx;
            end
            if (n_idx != NULL_IDX) begin
               prev_ff[n_idx[AW-1:0]] <= p_idx;
            end
            if (!do_push) begin
               prev_ff[cur_a] <= NULL_IDX;
               next_ff[cur_a] <= NULL_IDX;
               mode_ff[cur_a] <= MODE_HELD;
            end
         end
         if (do_push) begin
            prev_ff[cur_a] <= NULL_IDX;
            next_ff[cur_a] <= free_ff;
            free_ff        <= cur_ff;
            mode_ff[cur_a] <= MODE_FREE;
         end
      end
   end

   // item registers and walk pointer
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
         now_ff <= req_now_time;
         if (req_opcode == OP_INSERT) begin
            cur_ff <= free_ff;
         end else if (req_opcode == OP_RELEASE) begin
            cur_ff <= sin_ok ? IW'(32'(req_slot_in)) : NULL_IDX;
         end else begin
            cur_ff <= head_ff;
         end
      end else if (cmd.advance) begin
         cur_ff <= n_idx;
      end
      if (cmd.insert) begin
         res_status_ff <= insert_ok ? ST_OK : ST_FULL;
         res_slot_ff   <= insert_ok ? 4'(cur_ff) : 4'd0;
         res_key_ff    <= insert_ok ? key_ff : 32'd0;
      end
      if (cmd.fail) begin
         case (op_ff)
            OP_SWEEP:   res_status_ff <= ST_NONE_EXP;
            OP_RELEASE: res_status_ff <= ST_NOT_HELD;
            default:    res_status_ff <= ST_NOT_FOUND;
         endcase
         res_slot_ff <= 4'd0;
         res_key_ff  <= 32'd0;
      end
      if (cmd.apply) begin
         res_status_ff <= ST_OK;
         res_slot_ff   <= 4'(cur_ff);
         res_key_ff    <= key_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_we) begin
            timeout_ff <= cfg_wdata;
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_key_ff    <= res_key_ff;
      end
   end

   assign cfg_timeout  = timeout_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot_out = rsp_slot_ff;
   assign rsp_key_out  = rsp_key_ff;

   a_lists_apart: assert property (@(posedge clock) disable iff (reset)
      head_ff != NULL_IDX |-> head_ff != free_ff)
      else $error("slot on both lists");
   a_insert_head: assert property (@(posedge clock) disable iff (reset)
      insert_ok |=> head_ff == $past(free_ff))
      else $error("insert did not link at head");
   a_head_active: assert property (@(posedge clock) disable iff (reset)
      head_ff != NULL_IDX |-> mode_ff[head_ff[AW-1:0]] == MODE_ACTIVE)
      else $error("head slot not active");

endmodule

`default_nettype wire

### sv/aging_key_table_unit.sv
// ============================================================================
// aging_key_table_unit
// Slot pool with LIFO free stack and newest-first active list of aged keys.
// ============================================================================
// Usage:
//   req_* carries one item (opcode, key, now_time, slot_in) under valid/stall.
//   An item is taken only while the unit is idle; req_stall is high while
//   an item is in work. Opcodes 6 and 7 are taken and dropped, no result.
//   rsp_* returns one item (status, slot_out, key_out) per other opcode.
//   Insert runs the insert and done states. Release reads the named slot
//   and applies, or fails when refused; find, delete, refresh and sweep
//   walk the list to a hit, which is applied, or to its end, which fails.
//   The walk costs one key/stamp RAM read and one compare per entry. The
//   result sits in an output register; a new item may be taken while it waits.
//   A stalled result holds; the finished next result then waits. Reset
//   empties the table, puts all slots on the free stack and sets timeout_ticks
//   to 30. timeout_ticks sits at byte address 0 of the APB port and is
//   written by the user only while the unit is idle, not enforced by the unit.
// ============================================================================
`default_nettype none

module aging_key_table_unit
   import akt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [31:0] req_key,
   input  wire logic [31:0] req_now_time,
   input  wire logic [3:0]  req_slot_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_slot_out,
   output logic [31:0]      rsp_key_out,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   akt_cmd_type  cmd;
   akt_stat_type stat;
   logic         cfg_we;
   logic [31:0]  timeout;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && (paddr == 3'd0);
   assign prdata = (paddr == 3'd0) ? timeout : 32'd0;

   akt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   akt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_opcode   (req_opcode),
      .req_key      (req_key),
      .req_now_time (req_now_time),
      .req_slot_in  (req_slot_in),
      .cfg_we       (cfg_we),
      .cfg_wdata    (pwdata),
      .cfg_timeout  (timeout),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_slot_out (rsp_slot_out),
      .rsp_key_out  (rsp_key_out)
   );

endmodule

`default_nettype wire
